// ===== design/ps2sq_pkg.sv =====
`default_nettype none

package ps2sq_pkg;

    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_EXT    = 8'hE0;
    localparam logic [6:0] CODE_LSHIFT = 7'h2A;
    localparam logic [6:0] CODE_RSHIFT = 7'h36;
    localparam logic [6:0] CODE_CAPS   = 7'h3A;

    localparam int MOD_LSHIFT  = 0;
    localparam int MOD_RSHIFT  = 1;
    localparam int MOD_CAPS    = 2;
    localparam int MOD_RELEASE = 3;

    localparam int CODE_W  = 7;
    localparam int MODS_W  = 4;
    localparam int LIVE_W  = 3;
    localparam int ENTRY_W = CODE_W + MODS_W;

    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_POP  = 1'b1
    } item_kind_t;

    // ring entry: code in bits 6..0, modifiers in bits 10..7
    typedef struct packed {
        logic [MODS_W-1:0] mods;
        logic [CODE_W-1:0] code;
    } ring_entry_t;

    typedef struct packed {
        logic        push;
        ring_entry_t entry;
    } key_event_t;

endpackage

`default_nettype wire

// ===== design/ps2sq_ram.sv =====
`default_nettype none

module ps2sq_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/ps2sq_keymap.sv =====
`default_nettype none

module ps2sq_keymap (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   byte_en,
    input  wire logic [7:0]             scan_byte,
    output ps2sq_pkg::key_event_t       key_event
);

    import ps2sq_pkg::*;

    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_next;
    logic              ignored;
    logic              is_break;
    logic [CODE_W-1:0] code;
    logic [MODS_W-1:0] snap;

    assign ignored  = (scan_byte == BYTE_ACK) || (scan_byte == BYTE_EXT);
    assign is_break = scan_byte[7];
    assign code     = scan_byte[CODE_W-1:0];

    always_comb begin
        live_next = live_reg;
        snap      = '0;
        if (is_break) begin
            // snapshot goes out before the shift bit drops
            snap                = {1'b0, live_reg};
            snap[MOD_RELEASE]   = 1'b1;
            if (code == CODE_LSHIFT) begin
                live_next[MOD_LSHIFT] = 1'b0;
            end
            if (code == CODE_RSHIFT) begin
                live_next[MOD_RSHIFT] = 1'b0;
            end
        end else begin
            if (code == CODE_LSHIFT) begin
                live_next[MOD_LSHIFT] = 1'b1;
            end
            if (code == CODE_RSHIFT) begin
                live_next[MOD_RSHIFT] = 1'b1;
            end
            if (code == CODE_CAPS) begin
                live_next[MOD_CAPS] = ~live_reg[MOD_CAPS];
            end
            snap = {1'b0, live_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else if (byte_en && !ignored) begin
            live_reg <= live_next;
        end
    end

    // push, then modifiers, then code
    assign key_event = {byte_en && !ignored, snap, code};

endmodule

`default_nettype wire

// ===== design/ps2_scancode_event_queue_top.sv =====
`default_nettype none

// channel  dir  tdata (low bit up)                               tuser
// s_axis   in   [7:0] scan_byte                                  [0] kind (0 byte, 1 pop)
// m_axis   out  [6:0] key_code, [10:7] modifier_bits,            [0] event_valid
//               [11] dropped_flag, [15:12] zero
//
// one transaction per clock sustained while no pop is held by a stalled m_axis; a pop
// result passes from the input register, with the ring read, into the result register
// a scancode byte gives no result and is retired in the cycle after acceptance
// reset clears pointers, live modifiers and the dropped flag; no clearing pass
// a stalled m_axis holds the result; s_axis keeps accepting while the input
// register is empty or holds a scancode byte

module ps2_scancode_event_queue_top #(
    parameter int RING_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [6:0] key_code, [10:7] modifier_bits,
                                             // [11] dropped_flag
    output logic      [0:0]  m_axis_tuser    // [0] event_valid
);

    import ps2sq_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    // input register
    logic       a_valid_reg;
    item_kind_t a_kind_reg;
    logic [7:0] a_byte_reg;

    // ring state
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic             lost_reg;

    // result register
    logic b_valid_reg;
    logic b_hit_reg;
    logic b_lost_reg;

    logic        a_is_pop;
    logic        a_adv;
    logic        b_ready;
    logic        empty;
    logic        full;
    logic        push_fire;
    logic        pop_fire;
    logic        pop_hit;
    key_event_t  key_event;
    ring_entry_t rd_entry;

    assign a_is_pop = a_valid_reg && (a_kind_reg == KIND_POP);
    assign b_ready  = !b_valid_reg || m_axis_tready;
    assign a_adv    = !a_is_pop || b_ready;

    assign s_axis_tready = a_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_adv) begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && s_axis_tvalid) begin
            a_kind_reg <= item_kind_t'(s_axis_tuser[0]);
            a_byte_reg <= s_axis_tdata;
        end
    end

    ps2sq_keymap u_keymap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (a_valid_reg && (a_kind_reg == KIND_BYTE)),
        .scan_byte (a_byte_reg),
        .key_event (key_event)
    );

    // pointer increment with wrap for any depth
    always_comb begin
        if (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) begin
            wr_ptr_next = '0;
        end else begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_ptr_reg == PTR_W'(RING_DEPTH - 1)) begin
            rd_ptr_next = '0;
        end else begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
    end

    // one slot stays free to tell full from empty
    assign empty     = (rd_ptr_reg == wr_ptr_reg);
    assign full      = (wr_ptr_next == rd_ptr_reg);
    assign push_fire = key_event.push && !full;
    assign pop_fire  = a_is_pop && b_ready;
    assign pop_hit   = pop_fire && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            lost_reg   <= 1'b0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (key_event.push && full) begin
                lost_reg <= 1'b1;
            end
            if (pop_hit) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    ps2sq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (push_fire),
        .wr_addr (wr_ptr_reg),
        .wr_data (key_event.entry),
        .rd_en   (pop_hit),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_is_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            b_hit_reg  <= !empty;
            b_lost_reg <= lost_reg;
        end
    end

    assign m_axis_tvalid = b_valid_reg;
    assign m_axis_tuser  = b_hit_reg;
    assign m_axis_tdata  = {4'b0000,
                            b_lost_reg,
                            b_hit_reg ? rd_entry.mods : {MODS_W{1'b0}},
                            b_hit_reg ? rd_entry.code : {CODE_W{1'b0}}};

endmodule

`default_nettype wire

// ===== test/tb_ps2_scancode_event_queue_top.sv =====
`timescale 1ns / 1ps

module tb_ps2_scancode_event_queue_top;

    import ps2sq_pkg::*;

    localparam int RING_SLOTS  = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        bit              valid;
        bit [CODE_W-1:0] code;
        bit [MODS_W-1:0] mods;
        bit              dropped;
    } pop_report_t;

    class key_event_tracker;
        bit [LIVE_W-1:0] live_mods;
        ring_entry_t     ring[];
        int unsigned     wr_ptr;
        int unsigned     rd_ptr;
        bit              lost;
        int unsigned     depth;
        pop_report_t     pending_reports[$];
        int unsigned     errors;
        int unsigned     bytes_seen;
        int unsigned     pops_seen;
        int unsigned     events_popped;
        int unsigned     events_lost;
        int unsigned     results_checked;

        function new(int unsigned ring_depth);
            depth = ring_depth;
            ring = new[ring_depth];
            live_mods = '0;
            wr_ptr = 0;
            rd_ptr = 0;
            lost = 1'b0;
            errors = 0;
            bytes_seen = 0;
            pops_seen = 0;
            events_popped = 0;
            events_lost = 0;
            results_checked = 0;
        endfunction

        task report_mismatch(string field, int unsigned got, int unsigned want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
            errors++;
        endtask

        // advance the keyboard state and ring for one accepted transaction
        function void note_item(item_kind_t kind, logic [7:0] scan);
            logic [CODE_W-1:0] code;
            logic [MODS_W-1:0] snap;
            int unsigned       nxt;
            pop_report_t       rep;
            if (kind == KIND_BYTE) begin
                bytes_seen++;
                if (scan == BYTE_ACK || scan == BYTE_EXT)
                    return;
                code = scan[6:0];
                if (scan[7]) begin
                    // release snapshot keeps the shift bit that is about to clear
                    snap = {1'b1, live_mods};
                    if (code == CODE_LSHIFT) live_mods[MOD_LSHIFT] = 1'b0;
                    if (code == CODE_RSHIFT) live_mods[MOD_RSHIFT] = 1'b0;
                end else begin
                    if (code == CODE_LSHIFT) live_mods[MOD_LSHIFT] = 1'b1;
                    if (code == CODE_RSHIFT) live_mods[MOD_RSHIFT] = 1'b1;
                    if (code == CODE_CAPS) live_mods[MOD_CAPS] = ~live_mods[MOD_CAPS];
                    snap = {1'b0, live_mods};
                end
                nxt = (wr_ptr + 1) % depth;
                if (nxt != rd_ptr) begin
                    ring[wr_ptr].code = code;
                    ring[wr_ptr].mods = snap;
                    wr_ptr = nxt;
                end else begin
                    lost = 1'b1;
                    events_lost++;
                end
            end else begin
                pops_seen++;
                if (rd_ptr == wr_ptr) begin
                    rep.valid = 1'b0;
                    rep.code = '0;
                    rep.mods = '0;
                end else begin
                    rep.valid = 1'b1;
                    rep.code = ring[rd_ptr].code;
                    rep.mods = ring[rd_ptr].mods;
                    rd_ptr = (rd_ptr + 1) % depth;
                    events_popped++;
                end
                rep.dropped = lost;
                pending_reports.push_back(rep);
            end
        endfunction

        task check_pop_result(logic [15:0] tdata, logic [0:0] tuser);
            pop_report_t want;
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected result", tdata, 0);
                return;
            end
            want = pending_reports.pop_front();
            results_checked++;
            if (tuser[0] !== want.valid)
                report_mismatch("event_valid", tuser[0], want.valid);
            if (tdata[6:0] !== want.code)
                report_mismatch("key_code", tdata[6:0], want.code);
            if (tdata[10:7] !== want.mods)
                report_mismatch("modifier_bits", tdata[10:7], want.mods);
            if (tdata[11] !== want.dropped)
                report_mismatch("dropped_flag", tdata[11], want.dropped);
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic [7:0]  s_data;
    logic [0:0]  s_user;
    logic        m_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;
    wire  [0:0]  m_axis_tuser;

    key_event_tracker tracker;
    int unsigned      cycles;
    int unsigned      stall_left;
    bit               quiet_send;
    bit               quiet_recv;
    int               extra_fails;

    ps2_scancode_event_queue_top #(
        .RING_DEPTH(RING_SLOTS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),     // [7:0] scan_byte
        .s_axis_tuser  (s_user),     // [0] kind
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata), // [6:0] key_code, [10:7] modifier_bits, [11] dropped_flag
        .m_axis_tuser  (m_axis_tuser)  // [0] event_valid
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = '0;
        m_ready = 1'b0;
        cycles = 0;
        stall_left = 0;
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        extra_fails = 0;
        tracker = new(RING_SLOTS);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     tracker.pending_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: check on handshake, then pick ready for the next edge
    always @(posedge aclk) begin
        int unsigned r;
        if (aresetn && m_axis_tvalid && m_ready)
            tracker.check_pop_result(m_axis_tdata, m_axis_tuser);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (quiet_recv) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                m_ready <= 1'b1;
            end else if (r < 92) begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                stall_left <= $urandom_range(7, 39);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_send) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_item(item_kind_t kind, logic [7:0] scan);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= scan;
        s_user <= kind;
        do @(posedge aclk); while (!s_axis_tready);
        tracker.note_item(kind, scan);
    endtask

    function automatic logic [7:0] pick_scan();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return r[0] ? BYTE_ACK : BYTE_EXT;
        if (r < 35) begin
            case ($urandom_range(0, 5))
                0: return {1'b0, CODE_LSHIFT};
                1: return {1'b0, CODE_RSHIFT};
                2: return {1'b0, CODE_CAPS};
                3: return {1'b1, CODE_LSHIFT};
                4: return {1'b1, CODE_RSHIFT};
                default: return {1'b1, CODE_CAPS};
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int unsigned sent;
        int unsigned burst_len;
        int unsigned pop_pct;
        item_kind_t  kind;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty pop, ignored bytes, every modifier make and break, extreme codes
        send_item(KIND_POP, 8'h00);
        send_item(KIND_BYTE, BYTE_ACK);
        send_item(KIND_BYTE, BYTE_EXT);
        send_item(KIND_BYTE, {1'b0, CODE_LSHIFT});
        send_item(KIND_BYTE, 8'h1E);
        send_item(KIND_BYTE, {1'b0, CODE_RSHIFT});
        send_item(KIND_BYTE, {1'b0, CODE_CAPS});
        send_item(KIND_BYTE, 8'h9E);
        send_item(KIND_BYTE, {1'b1, CODE_LSHIFT});
        send_item(KIND_BYTE, {1'b1, CODE_RSHIFT});
        send_item(KIND_BYTE, {1'b1, CODE_CAPS});
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hFF);
        send_item(KIND_BYTE, 8'h80);
        // pop with a nonzero byte that must be ignored
        send_item(KIND_POP, 8'hFF);
        repeat (11) send_item(KIND_POP, 8'($urandom_range(0, 255)));

        // random bursts: push-heavy ones overflow the ring, pop-heavy ones drain it
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: pop_pct = 5;
                1: pop_pct = 50;
                default: pop_pct = 85;
            endcase
            quiet_send = ($urandom_range(0, 3) == 0);
            quiet_recv = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                kind = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_BYTE;
                send_item(kind, kind == KIND_POP ? 8'($urandom_range(0, 255)) : pick_scan());
                sent++;
            end
        end
        // drop valid right after the last accepting edge so nothing is sent twice
        s_valid <= 1'b0;
        quiet_recv = 1'b0;

        while (tracker.pending_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.pending_reports.size() != 0) begin
            $display("%0d results never arrived", tracker.pending_reports.size());
            extra_fails++;
        end

        $display("sent %0d scancode bytes and %0d pops; %0d events returned, %0d lost to a full ring",
                 tracker.bytes_seen, tracker.pops_seen, tracker.events_popped,
                 tracker.events_lost);
        $display("checked %0d results, %0d mismatches", tracker.results_checked, tracker.errors);
        if (tracker.errors == 0 && extra_fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
